// ===== sv/cbd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbd_pkg: shared types and constants of the console bus decoder
// Operation, status and device codes, peripheral window bounds and the
// decode result that travels from the decoder to the top level.
// ----------------------------------------------------------------------------
package cbd_pkg;

    typedef logic [1:0] t_op;
    typedef logic [2:0] t_status;
    typedef logic [2:0] t_device;
    typedef logic [1:0] t_cfg_index;

    localparam t_op OP_READ  = 2'd0;
    localparam t_op OP_WRITE = 2'd1;
    localparam t_op OP_FILL  = 2'd2;

    localparam t_status ST_RAM         = 3'd0;
    localparam t_status ST_ROM_READ    = 3'd1;
    localparam t_status ST_ROM_IGNORED = 3'd2;
    localparam t_status ST_FORWARD     = 3'd3;
    localparam t_status ST_UNMAPPED    = 3'd4;
    localparam t_status ST_BAD         = 3'd5;

    localparam t_device DEV_NONE  = 3'd0;
    localparam t_device DEV_PI    = 3'd1;
    localparam t_device DEV_MI    = 3'd2;
    localparam t_device DEV_DSP   = 3'd3;
    localparam t_device DEV_DI    = 3'd4;
    localparam t_device DEV_SI    = 3'd5;
    localparam t_device DEV_EXI   = 3'd6;
    localparam t_device DEV_AUDIO = 3'd7;

    localparam t_cfg_index CFG_ROM_BASE   = 2'd0;
    localparam t_cfg_index CFG_ROM_LENGTH = 2'd1;

    localparam logic [31:0] ROM_BASE_RESET = 32'hFFF0_0000;

    // Peripheral window boundaries on the bus.
    localparam logic [31:0] PI_BASE    = 32'hCC00_3000;
    localparam logic [31:0] MI_BASE    = 32'hCC00_4000;
    localparam logic [31:0] DSP_BASE   = 32'hCC00_5000;
    localparam logic [31:0] DI_BASE    = 32'hCC00_6000;
    localparam logic [31:0] SI_BASE    = 32'hCC00_6400;
    localparam logic [31:0] EXI_BASE   = 32'hCC00_6800;
    localparam logic [31:0] AUDIO_ADDR = 32'hCC00_6C00;
    localparam logic [31:0] PERIPH_END = 32'hCC00_8000;

    // RAM segments: top nibble 0x0, 0x8 or 0xC, low 28 bits are the offset.
    localparam logic [3:0]  SEG_PHYS   = 4'h0;
    localparam logic [3:0]  SEG_CACHED = 4'h8;
    localparam logic [3:0]  SEG_UNCACH = 4'hC;
    localparam logic [27:0] OFF_MASK   = 28'hFFF_FFFF;

    // Eight byte lanes cover the widest access.
    localparam int LANES  = 8;
    localparam int LANE_W = 3;

    typedef struct packed {
        logic    ram_rd;
        logic    ram_wr;
        logic    rom_rd;
        logic    rom_fill;
        t_status status;
        t_device device;
    } t_dec;

endpackage

// ===== sv/cbd_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbd_ram: generic synchronous RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module cbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/cbd_bank.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbd_bank: byte memory built from eight byte-lane RAMs
// Steers a big-endian access of 1 to 8 bytes at any byte offset onto the
// lanes, so an unaligned access touches each lane at most once, and builds
// the read data from the registered lane outputs. An optional sweep zeroes whole rows.
// ----------------------------------------------------------------------------
module cbd_bank
    import cbd_pkg::*;
#(
    parameter int BYTES = 65536
) (
    input  logic                                      i_clk,
    input  logic                                      i_rd,
    input  logic                                      i_wr,
    input  logic [$clog2((BYTES+LANES-1)/LANES)+LANE_W-1:0] i_off,
    input  logic [3:0]                                i_size,
    input  logic [63:0]                               i_wdata,
    input  logic                                      i_clr,
    input  logic [$clog2((BYTES+LANES-1)/LANES)-1:0]  i_clr_row,
    output logic [63:0]                               o_rdata
);

    localparam int ROWS  = (BYTES + LANES - 1) / LANES;
    localparam int ROW_W = $clog2(ROWS);
    localparam int OFF_W = ROW_W + LANE_W;

    logic [ROW_W-1:0]  w_row0;
    logic [LANE_W-1:0] w_off_lo;
    logic [LANE_W-1:0] w_nm1;
    logic [LANES-1:0]  w_act;
    logic [ROW_W-1:0]  w_row   [LANES];
    logic [7:0]        w_byte  [LANES];
    logic [7:0]        w_q     [LANES];
    logic [LANE_W-1:0] r_off_lo;
    logic [LANE_W-1:0] r_nm1;

    assign w_row0   = i_off[OFF_W-1:LANE_W];
    assign w_off_lo = i_off[LANE_W-1:0];
    assign w_nm1    = LANE_W'(i_size - 4'd1);

    // Byte i of the access lands in lane (offset + i) mod 8; lanes below the
    // starting lane belong to the next row.
    always_comb begin
        logic [LANE_W-1:0] idx;
        logic [LANE_W-1:0] k;
        for (int b = 0; b < LANES; b++) begin
            idx       = LANE_W'(b) - w_off_lo;
            k         = w_nm1 - idx;
            w_act[b]  = ({1'b0, idx} < i_size);
            w_row[b]  = w_row0 + ROW_W'(LANE_W'(b) < w_off_lo);
            w_byte[b] = i_wdata[{k, 3'b000} +: 8];
        end
    end

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        cbd_ram #(
            .WIDTH (8),
            .DEPTH (ROWS)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (i_clr | (i_wr & w_act[g])),
            .i_waddr (i_clr ? i_clr_row : w_row[g]),
            .i_wdata (i_clr ? 8'h00 : w_byte[g]),
            .i_re    (i_rd & w_act[g]),
            .i_raddr (w_row[g]),
            .o_rdata (w_q[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (i_rd) begin
            r_off_lo <= w_off_lo;
            r_nm1    <= w_nm1;
        end
    end

    // Output byte k (counted from the least significant end) is access
    // byte nm1 - k; bytes above the access size read as zero.
    always_comb begin
        logic [LANE_W-1:0] idx;
        logic [LANE_W-1:0] lane;
        o_rdata = '0;
        for (int k = 0; k < LANES; k++) begin
            idx  = r_nm1 - LANE_W'(k);
            lane = r_off_lo + idx;
            if (LANE_W'(k) <= r_nm1) begin
                o_rdata[k*8 +: 8] = w_q[lane];
            end
        end
    end

endmodule

// ===== sv/cbd_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbd_decode: address and size decode of one bus beat
// Classifies the access as RAM, boot ROM, fill, peripheral or unmapped,
// checks size and overrun, and gives the byte offsets into both memories.
// ----------------------------------------------------------------------------
module cbd_decode
    import cbd_pkg::*;
#(
    parameter int RAM_BYTES = 65536,
    parameter int ROM_BYTES = 65536
) (
    input  t_op                                             i_op,
    input  logic [31:0]                                     i_adr,
    input  logic [3:0]                                      i_size,
    input  logic [31:0]                                     i_rom_base,
    input  logic [16:0]                                     i_rom_length,
    output t_dec                                            o_dec,
    output logic [$clog2((RAM_BYTES+LANES-1)/LANES)+LANE_W-1:0] o_ram_off,
    output logic [$clog2((ROM_BYTES+LANES-1)/LANES)+LANE_W-1:0] o_rom_off
);

    localparam int RAM_OFF_W = $clog2((RAM_BYTES + LANES - 1) / LANES) + LANE_W;
    localparam int ROM_OFF_W = $clog2((ROM_BYTES + LANES - 1) / LANES) + LANE_W;
    localparam logic [28:0] RAM_LIM      = 29'(RAM_BYTES);
    localparam logic [21:0] ROM_LIM      = 22'(ROM_BYTES);
    localparam logic [32:0] ROM_FILL_LIM = 33'(ROM_BYTES);

    logic        w_size_ok;
    logic [3:0]  w_seg;
    logic [27:0] w_off;
    logic        w_in_ram;
    logic        w_ram_over;
    logic [21:0] w_win;
    logic [31:0] w_roff;
    logic        w_in_rom;
    logic        w_rom_over;
    logic        w_fill_over;
    t_device     w_dev;

    assign w_size_ok = (i_size == 4'd1) || (i_size == 4'd2) ||
                       (i_size == 4'd4) || (i_size == 4'd8);

    assign w_seg      = i_adr[31:28];
    assign w_off      = i_adr[27:0] & OFF_MASK;
    assign w_in_ram   = ((w_seg == SEG_PHYS) || (w_seg == SEG_CACHED) ||
                         (w_seg == SEG_UNCACH)) && ({1'b0, w_off} < RAM_LIM);
    assign w_ram_over = ({1'b0, w_off} + 29'(i_size)) > RAM_LIM;

    assign w_win      = ({5'd0, i_rom_length} < ROM_LIM) ? {5'd0, i_rom_length} : ROM_LIM;
    assign w_roff     = i_adr - i_rom_base;
    assign w_in_rom   = (i_adr >= i_rom_base) && (w_roff < {10'd0, w_win});
    assign w_rom_over = ({1'b0, w_roff[21:0]} + 23'(i_size)) > {1'b0, w_win};

    assign w_fill_over = ({1'b0, i_adr} + 33'(i_size)) > ROM_FILL_LIM;

    always_comb begin
        w_dev = DEV_NONE;
        if (i_adr >= PI_BASE && i_adr < MI_BASE) begin
            w_dev = DEV_PI;
        end else if (i_adr >= MI_BASE && i_adr < DSP_BASE) begin
            w_dev = DEV_MI;
        end else if (i_adr >= DSP_BASE && i_adr < DI_BASE) begin
            w_dev = DEV_DSP;
        end else if (i_adr >= DI_BASE && i_adr < SI_BASE) begin
            w_dev = DEV_DI;
        end else if (i_adr >= SI_BASE && i_adr < EXI_BASE) begin
            w_dev = DEV_SI;
        end else if (i_adr >= EXI_BASE && i_adr < AUDIO_ADDR) begin
            w_dev = DEV_EXI;
        end else if (i_adr == AUDIO_ADDR) begin
            w_dev = DEV_AUDIO;
        end
    end

    // Decode priority: size, then fill, then RAM, then the ROM window, then peripherals.
    always_comb begin
        o_dec = '{ram_rd: 1'b0, ram_wr: 1'b0, rom_rd: 1'b0, rom_fill: 1'b0,
                  status: ST_UNMAPPED, device: DEV_NONE};
        if (!w_size_ok) begin
            o_dec.status = ST_BAD;
        end else if (i_op == OP_FILL) begin
            if (w_fill_over) begin
                o_dec.status = ST_BAD;
            end else begin
                o_dec.rom_fill = 1'b1;
                o_dec.status   = ST_RAM;
            end
        end else if (i_op == OP_READ || i_op == OP_WRITE) begin
            if (w_in_ram) begin
                if (w_ram_over) begin
                    o_dec.status = ST_BAD;
                end else begin
                    o_dec.ram_rd = (i_op == OP_READ);
                    o_dec.ram_wr = (i_op == OP_WRITE);
                    o_dec.status = ST_RAM;
                end
            end else if (w_in_rom) begin
                if (w_rom_over) begin
                    o_dec.status = ST_BAD;
                end else if (i_op == OP_READ) begin
                    o_dec.rom_rd = 1'b1;
                    o_dec.status = ST_ROM_READ;
                end else begin
                    o_dec.status = ST_ROM_IGNORED;
                end
            end else begin
                o_dec.device = w_dev;
                o_dec.status = (w_dev != DEV_NONE) ? ST_FORWARD : ST_UNMAPPED;
            end
        end
    end

    assign o_ram_off = w_off[RAM_OFF_W-1:0];
    assign o_rom_off = (i_op == OP_FILL) ? i_adr[ROM_OFF_W-1:0] : w_roff[ROM_OFF_W-1:0];

endmodule

// ===== sv/console_bus_decode_big_endian_ram_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// console_bus_decode_big_endian_ram_core: console bus decoder with main RAM
// and boot ROM
// Decodes bus beats to big-endian main RAM, a boot ROM window, seven
// peripheral windows or unmapped space, and answers each with one result.
// ----------------------------------------------------------------------------
// After reset the block clears main RAM one 8-byte row per cycle; input
// beats are stalled during that sweep, while configuration writes are taken
// at any time. After that each beat passes through two states: in the idle
// state the address is decoded and the access is issued to the RAM or ROM,
// in the data state the registered read data comes back from the memory
// and the result is loaded into the output register as soon as that
// register is empty or its result is being taken. The next beat is accepted
// only once the result is in the output register, so the block does not take
// a new beat while one is in flight. Both memories are split into eight
// byte-lane RAMs, so any access of 1, 2, 4 or 8 bytes at any byte offset
// reaches each lane at most once and completes in a single memory access.
// Configure rom_base and rom_length only while no beat is in flight.
// ----------------------------------------------------------------------------
module console_bus_decode_big_endian_ram_core
    import cbd_pkg::*;
#(
    parameter int RAM_BYTES = 65536,
    parameter int ROM_BYTES = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port.
    input  logic        i_cfg_we,
    input  t_cfg_index  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    // Input beat channel.
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_operation,
    input  logic [31:0] i_address,
    input  logic [3:0]  i_size_bytes,
    input  logic [63:0] i_write_data,
    // Result beat channel.
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_read_data,
    output logic [2:0]  o_status,
    output logic [2:0]  o_device
);

    localparam int RAM_ROWS  = (RAM_BYTES + LANES - 1) / LANES;
    localparam int RAM_ROW_W = $clog2(RAM_ROWS);
    localparam int RAM_OFF_W = RAM_ROW_W + LANE_W;
    localparam int ROM_ROWS  = (ROM_BYTES + LANES - 1) / LANES;
    localparam int ROM_ROW_W = $clog2(ROM_ROWS);
    localparam int ROM_OFF_W = ROM_ROW_W + LANE_W;
    localparam logic [RAM_ROW_W-1:0] LAST_ROW = RAM_ROW_W'(RAM_ROWS - 1);

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_DATA  = 3'b100
    } t_state;

    t_state                 r_state, n_state;
    logic [RAM_ROW_W-1:0]   r_clr_row, n_clr_row;
    logic [31:0]            r_rom_base;
    logic [16:0]            r_rom_length;
    t_dec                   r_dec;
    logic                   r_out_valid, n_out_valid;
    logic [63:0]            r_read_data;
    t_status                r_status;
    t_device                r_device;

    t_dec                   w_dec;
    logic [RAM_OFF_W-1:0]   w_ram_off;
    logic [ROM_OFF_W-1:0]   w_rom_off;
    logic [63:0]            w_ram_q;
    logic [63:0]            w_rom_q;
    logic                   w_in_accept;
    logic                   w_load;
    logic                   w_clearing;

    // A beat is taken only in the idle state; the sweep and the data cycle
    // both hold the input side off.
    assign w_in_accept = i_in_valid && (r_state == S_IDLE);
    assign w_clearing  = (r_state == S_CLEAR);
    // The result enters the output register in the data cycle, as soon as
    // the register is empty or its beat is being taken.
    assign w_load      = (r_state == S_DATA) && (!r_out_valid || !i_out_stall);

    cbd_decode #(
        .RAM_BYTES (RAM_BYTES),
        .ROM_BYTES (ROM_BYTES)
    ) u_decode (
        .i_op         (i_operation),
        .i_adr        (i_address),
        .i_size       (i_size_bytes),
        .i_rom_base   (r_rom_base),
        .i_rom_length (r_rom_length),
        .o_dec        (w_dec),
        .o_ram_off    (w_ram_off),
        .o_rom_off    (w_rom_off)
    );

    // Main RAM: cleared by the sweep after reset.
    cbd_bank #(
        .BYTES (RAM_BYTES)
    ) u_ram_bank (
        .i_clk     (i_clk),
        .i_rd      (w_in_accept && w_dec.ram_rd),
        .i_wr      (w_in_accept && w_dec.ram_wr),
        .i_off     (w_ram_off),
        .i_size    (i_size_bytes),
        .i_wdata   (i_write_data),
        .i_clr     (w_clearing),
        .i_clr_row (r_clr_row),
        .o_rdata   (w_ram_q)
    );

    // Boot ROM: written only by fill beats, never cleared.
    cbd_bank #(
        .BYTES (ROM_BYTES)
    ) u_rom_bank (
        .i_clk     (i_clk),
        .i_rd      (w_in_accept && w_dec.rom_rd),
        .i_wr      (w_in_accept && w_dec.rom_fill),
        .i_off     (w_rom_off),
        .i_size    (i_size_bytes),
        .i_wdata   (i_write_data),
        .i_clr     (1'b0),
        .i_clr_row ({ROM_ROW_W{1'b0}}),
        .o_rdata   (w_rom_q)
    );

    // Sequencer: clearing sweep, then idle / data alternation.
    always_comb begin
        n_state   = r_state;
        n_clr_row = r_clr_row;
        case (r_state)
            S_CLEAR: begin
                n_clr_row = r_clr_row + 1'b1;
                if (r_clr_row == LAST_ROW) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_in_accept) begin
                    n_state = S_DATA;
                end
            end
            S_DATA: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_row    <= '0;
            r_out_valid  <= 1'b0;
            r_rom_base   <= ROM_BASE_RESET;
            r_rom_length <= '0;
        end else begin
            r_state     <= n_state;
            r_clr_row   <= n_clr_row;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ROM_BASE:   r_rom_base   <= i_cfg_data;
                    CFG_ROM_LENGTH: r_rom_length <= i_cfg_data[16:0];
                    default:        ;
                endcase
            end
        end
    end

    // Decode result rides along to the data cycle; the result itself is
    // payload and needs no reset.
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_dec <= w_dec;
        end
        if (w_load) begin
            r_status    <= r_dec.status;
            r_device    <= r_dec.device;
            r_read_data <= r_dec.ram_rd ? w_ram_q :
                           r_dec.rom_rd ? w_rom_q : 64'd0;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_read_data = r_read_data;
    assign o_status    = r_status;
    assign o_device    = r_device;

    // An accepted beat always moves on to its data cycle.
    a_accept_to_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept |=> (r_state == S_DATA))
        else $error("accepted beat did not enter the data cycle");

    // A new result only appears after a data cycle.
    a_result_after_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DATA))
        else $error("result appeared without a data cycle");

    // At most one memory operation per beat.
    a_one_mem_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept |-> $onehot0({w_dec.ram_rd, w_dec.ram_wr, w_dec.rom_rd, w_dec.rom_fill}))
        else $error("decode issued more than one memory operation");

    // A device number is reported only with a forwarded status.
    a_device_forward: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_device != DEV_NONE)) |-> (r_status == ST_FORWARD))
        else $error("device number without forwarded status");

    // No beat is taken while main RAM is being cleared.
    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clearing |-> !w_in_accept)
        else $error("beat accepted during RAM clear");

endmodule

// ===== tb/sv/tb_console_bus_decode_big_endian_ram_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_console_bus_decode_big_endian_ram_core: self-checking bench of the bus
// decoder
// Drives bus beats through the decoder under random gaps and stalls on both
// channels. An in-bench memory image of main RAM and boot ROM predicts every
// result, which is checked field by field. The run steps through several
// boot ROM window settings, the extremes among them.
// ----------------------------------------------------------------------------
module tb_console_bus_decode_big_endian_ram_core;
    import cbd_pkg::*;

    localparam int MAIN_RAM_BYTES = 65536;
    localparam int ROM_SIZE = 65536;
    // The block sweeps main RAM one 8-byte row per cycle after reset, so the
    // first beat can sit stalled for that long. The limit allows it several
    // times over.
    localparam int NO_PROGRESS_LIMIT = 5 * (MAIN_RAM_BYTES / 8);
    localparam int PHASES = 8;
    localparam int BEATS_PER_PHASE = 1500 / PHASES;

    // Operation code 3 is unused; with a legal size the decoder must answer it as unmapped.
    localparam t_op OP_SPARE = 2'd3;

    typedef struct {
        t_op         op;
        logic [31:0] addr;
        logic [3:0]  size;
        logic [63:0] wdata;
    } t_bus_beat;

    typedef struct {
        logic [63:0] rdata;
        t_status     status;
        t_device     device;
    } t_bus_reply;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    t_cfg_index  i_cfg_index;
    logic [31:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_operation;
    logic [31:0] i_address;
    logic [3:0]  i_size_bytes;
    logic [63:0] i_write_data;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [63:0] o_read_data;
    logic [2:0]  o_status;
    logic [2:0]  o_device;

    console_bus_decode_big_endian_ram_core #(
        .RAM_BYTES (MAIN_RAM_BYTES),
        .ROM_BYTES (ROM_SIZE)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_operation  (i_operation),
        .i_address    (i_address),
        .i_size_bytes (i_size_bytes),
        .i_write_data (i_write_data),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_read_data  (o_read_data),
        .o_status     (o_status),
        .o_device     (o_device)
    );

    // ------------------------------------------------------------------------
    // Memory image and window settings as the bench believes them to be.
    // The image is updated in acceptance order, so each prediction sees
    // exactly the stores that the block has seen before it.
    // ------------------------------------------------------------------------
    logic [7:0]  ram_image [MAIN_RAM_BYTES];
    logic [7:0]  rom_image [ROM_SIZE];
    logic [31:0] cur_rom_base;
    logic [16:0] cur_rom_length;

    // Which ROM bytes the queued fills will have written. The generator uses
    // it so that no ROM read ever touches a byte that was never filled.
    bit          rom_filled [ROM_SIZE];

    t_bus_beat   pending_beats [$];
    t_bus_reply  expected_replies [$];
    t_bus_beat   cur_beat;

    bit          in_fire;
    bit          out_fire;
    bit          in_calm;
    bit          out_calm;
    int          gap_left;
    int          hold_left;
    int          mismatch_count;
    int          replies_seen;
    int          idle_cycles;

    function automatic bit legal_size(logic [3:0] size);
        return size == 4'd1 || size == 4'd2 || size == 4'd4 || size == 4'd8;
    endfunction

    function automatic bit in_ram_segment(logic [31:0] addr);
        return (addr[31:28] == SEG_PHYS || addr[31:28] == SEG_CACHED ||
                addr[31:28] == SEG_UNCACH) && addr[27:0] < MAIN_RAM_BYTES;
    endfunction

    // Effective window length: the register, capped at the ROM size.
    function automatic int rom_window();
        return (cur_rom_length < ROM_SIZE) ? int'(cur_rom_length) : ROM_SIZE;
    endfunction

    function automatic t_device device_at(logic [31:0] addr);
        if (addr >= PI_BASE && addr < MI_BASE) return DEV_PI;
        if (addr >= MI_BASE && addr < DSP_BASE) return DEV_MI;
        if (addr >= DSP_BASE && addr < DI_BASE) return DEV_DSP;
        if (addr >= DI_BASE && addr < SI_BASE) return DEV_DI;
        if (addr >= SI_BASE && addr < EXI_BASE) return DEV_SI;
        if (addr >= EXI_BASE && addr < AUDIO_ADDR) return DEV_EXI;
        // Only the first address of the audio stream block is decoded.
        if (addr == AUDIO_ADDR) return DEV_AUDIO;
        return DEV_NONE;
    endfunction

    // Works out the result of one beat and applies its stores to the image.
    // Decode order is size check, fill, RAM, ROM window, peripherals, so the
    // RAM segments shadow any part of the ROM window that overlaps them.
    function automatic t_bus_reply predict_access(t_bus_beat b);
        t_bus_reply  r;
        logic [31:0] off;
        logic [31:0] roff;
        int          win;
        int          n;
        int          i;
        r.rdata  = '0;
        r.status = ST_UNMAPPED;
        r.device = DEV_NONE;
        n        = int'(b.size);
        win      = rom_window();
        off      = {4'h0, b.addr[27:0]};
        roff     = b.addr - cur_rom_base;
        if (!legal_size(b.size)) begin
            r.status = ST_BAD;
        end else if (b.op == OP_FILL) begin
            // The fill address is a ROM byte offset; the sum is taken wide so
            // that offsets near the top of the address space cannot wrap.
            if (64'(b.addr) + 64'(n) > 64'(ROM_SIZE)) begin
                r.status = ST_BAD;
            end else begin
                for (i = 0; i < n; i++)
                    rom_image[int'(b.addr) + i] = b.wdata[8 * (n - 1 - i) +: 8];
                r.status = ST_RAM;
            end
        end else if (b.op == OP_READ || b.op == OP_WRITE) begin
            if (in_ram_segment(b.addr)) begin
                if (off + n > MAIN_RAM_BYTES) begin
                    r.status = ST_BAD;
                end else if (b.op == OP_READ) begin
                    for (i = 0; i < n; i++)
                        r.rdata = {r.rdata[55:0], ram_image[int'(off) + i]};
                    r.status = ST_RAM;
                end else begin
                    for (i = 0; i < n; i++)
                        ram_image[int'(off) + i] = b.wdata[8 * (n - 1 - i) +: 8];
                    r.status = ST_RAM;
                end
            end else if (b.addr >= cur_rom_base && roff < win) begin
                if (roff + n > win) begin
                    r.status = ST_BAD;
                end else if (b.op == OP_READ) begin
                    for (i = 0; i < n; i++)
                        r.rdata = {r.rdata[55:0], rom_image[int'(roff) + i]};
                    r.status = ST_ROM_READ;
                end else begin
                    r.status = ST_ROM_IGNORED;
                end
            end else begin
                r.device = device_at(b.addr);
                r.status = (r.device != DEV_NONE) ? ST_FORWARD : ST_UNMAPPED;
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Beat generation.
    // ------------------------------------------------------------------------
    function automatic t_bus_beat make_beat(t_op op, logic [31:0] addr,
                                            logic [3:0] size, logic [63:0] wdata);
        t_bus_beat b;
        b.op    = op;
        b.addr  = addr;
        b.size  = size;
        b.wdata = wdata;
        return b;
    endfunction

    function automatic logic [3:0] any_legal_size();
        return 4'd1 << $urandom_range(0, 3);
    endfunction

    function automatic logic [3:0] any_bad_size();
        logic [3:0] s;
        s = 4'($urandom_range(0, 15));
        while (legal_size(s))
            s = 4'($urandom_range(0, 15));
        return s;
    endfunction

    function automatic logic [3:0] any_ram_segment();
        case ($urandom_range(0, 2))
            0:       return SEG_PHYS;
            1:       return SEG_CACHED;
            default: return SEG_UNCACH;
        endcase
    endfunction

    // Queues one beat. A ROM read that would touch a byte never filled is
    // turned into a fill of the same bytes, so later reads there are defined.
    function automatic void queue_beat(t_bus_beat b);
        logic [31:0] roff;
        int          n;
        int          win;
        int          i;
        bit          holes;
        n     = int'(b.size);
        win   = rom_window();
        roff  = b.addr - cur_rom_base;
        holes = 1'b0;
        if (b.op == OP_READ && legal_size(b.size) && !in_ram_segment(b.addr) &&
            b.addr >= cur_rom_base && roff < win && roff + n <= win) begin
            for (i = 0; i < n; i++)
                if (!rom_filled[int'(roff) + i]) holes = 1'b1;
            if (holes) begin
                b.op   = OP_FILL;
                b.addr = roff;
            end
        end
        if (b.op == OP_FILL && legal_size(b.size) &&
            64'(b.addr) + 64'(n) <= 64'(ROM_SIZE)) begin
            for (i = 0; i < n; i++)
                rom_filled[int'(b.addr) + i] = 1'b1;
        end
        pending_beats.push_back(b);
    endfunction

    // Mostly well-formed accesses aimed at small hot regions so that reads
    // find earlier stores, plus edges of every window and some plain noise.
    function automatic t_bus_beat random_beat();
        t_bus_beat b;
        int        pick;
        int        win;
        int        off;
        b.op    = $urandom_range(0, 1) ? OP_WRITE : OP_READ;
        b.size  = any_legal_size();
        b.wdata = {$urandom, $urandom};
        b.addr  = $urandom;
        win     = rom_window();
        pick    = $urandom_range(0, 99);
        if (pick < 30) begin
            // Main RAM through any segment: hot start, top end or anywhere.
            case ($urandom_range(0, 3))
                0, 1:    off = $urandom_range(0, 255);
                2:       off = MAIN_RAM_BYTES - 256 + $urandom_range(0, 255);
                default: off = $urandom_range(0, MAIN_RAM_BYTES - 1);
            endcase
            b.addr = {any_ram_segment(), 28'(off)};
        end else if (pick < 35) begin
            // Accesses that start in the last bytes of RAM and may run off.
            b.addr = {any_ram_segment(), 28'(MAIN_RAM_BYTES - $urandom_range(1, 8))};
        end else if (pick < 55) begin
            // Boot ROM window: hot start, near the end, or anywhere inside.
            if (win == 0)
                off = $urandom_range(0, 15);
            else begin
                case ($urandom_range(0, 3))
                    0:       off = win - $urandom_range(1, (win < 8) ? win : 8);
                    1:       off = $urandom_range(0, win - 1);
                    default: off = $urandom_range(0, (win < 128) ? win - 1 : 127);
                endcase
            end
            b.addr = cur_rom_base + off;
            b.op   = ($urandom_range(0, 3) == 0) ? OP_WRITE : OP_READ;
        end else if (pick < 67) begin
            b.op = OP_FILL;
            case ($urandom_range(0, 4))
                0:       b.addr = $urandom_range(0, 127);
                1:       b.addr = ROM_SIZE - $urandom_range(1, 8);
                2:       b.addr = (win == 0) ? 0 : win - $urandom_range(1, (win < 8) ? win : 8);
                3:       b.addr = $urandom;
                default: b.addr = $urandom_range(0, ROM_SIZE - 1);
            endcase
        end else if (pick < 82) begin
            // Peripheral windows and the addresses just around them.
            case ($urandom_range(0, 5))
                0:       b.addr = AUDIO_ADDR + $urandom_range(0, 2) - 1;
                1:       b.addr = PI_BASE - $urandom_range(1, 4);
                2:       b.addr = PERIPH_END - $urandom_range(0, 3);
                default: b.addr = PI_BASE + $urandom_range(0, PERIPH_END - PI_BASE - 1);
            endcase
        end else if (pick < 88) begin
            b.op   = t_op'($urandom_range(0, 3));
            b.size = any_bad_size();
            if ($urandom_range(0, 1))
                b.addr = {any_ram_segment(), 28'($urandom_range(0, 255))};
        end else begin
            // Noise: any operation, the spare code included, at any address.
            b.op = t_op'($urandom_range(0, 3));
            if ($urandom_range(0, 4) == 0)
                b.size = 4'($urandom_range(0, 15));
        end
        return b;
    endfunction

    // ------------------------------------------------------------------------
    // Mismatch reporting: one line per mismatch, and each one is counted.
    // ------------------------------------------------------------------------
    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH at result %0d: %s got %h expected %h",
                 replies_seen, what, got, want);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------------
    // Clock.
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Input side. At each rising edge an accepted beat is handed to the
    // predictor, and its result joins the expectations in order.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        in_fire <= i_in_valid && !o_in_stall;
        if (i_in_valid && !o_in_stall)
            expected_replies.push_back(predict_access(cur_beat));
    end

    // The driver changes the payload only at a falling edge after the held
    // beat was taken, or when nothing is offered, so a stalled beat stays put.
    // Each beat draws the gap that follows it; calm stretches draw none.
    always @(negedge i_clk) begin
        if (!i_in_valid || in_fire) begin
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (pending_beats.size() != 0) begin
                cur_beat = pending_beats.pop_front();
                i_operation  <= cur_beat.op;
                i_address    <= cur_beat.addr;
                i_size_bytes <= cur_beat.size;
                i_write_data <= cur_beat.wdata;
                i_in_valid   <= 1'b1;
                if ($urandom_range(0, 49) == 0) in_calm = !in_calm;
                gap_left = in_calm ? 0 : $urandom_range(0, 9);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result side. Every accepted result is compared with the oldest
    // expectation; a result with nothing outstanding is a failure too.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : result_monitor
        t_bus_reply want;
        out_fire <= i_rst_n && o_out_valid && !i_out_stall;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_replies.size() == 0) begin
                report_mismatch("result with nothing outstanding, status", 64'(o_status), '0);
            end else begin
                want = expected_replies.pop_front();
                if (o_read_data !== want.rdata)
                    report_mismatch("read_data", o_read_data, want.rdata);
                if (o_status !== want.status)
                    report_mismatch("status", 64'(o_status), 64'(want.status));
                if (o_device !== want.device)
                    report_mismatch("device", 64'(o_device), 64'(want.device));
            end
            replies_seen++;
        end
    end

    // After each result is taken the receiver draws how long it stalls next.
    always @(negedge i_clk) begin
        if (out_fire) begin
            if ($urandom_range(0, 49) == 0) out_calm = !out_calm;
            hold_left = out_calm ? 0 : $urandom_range(0, 9);
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: counts cycles in which work is outstanding but no beat moves
    // on either channel.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (!i_in_valid && expected_replies.size() == 0) ||
            (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= NO_PROGRESS_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and run control.
    // ------------------------------------------------------------------------

    // Register writes happen only with the block idle, so the window settings
    // can be taken over by the predictor at the moment of the write.
    task automatic write_register(t_cfg_index idx, logic [31:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_ROM_BASE)
            cur_rom_base = value;
        else
            cur_rom_length = value[16:0];
    endtask

    // Waits until every queued beat is taken and every result has arrived.
    task automatic drain_block();
        while (pending_beats.size() != 0 || i_in_valid || expected_replies.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    initial begin : stimulus
        int phase;
        int k;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = CFG_ROM_BASE;
        i_cfg_data   = '0;
        i_in_valid   = 1'b0;
        i_operation  = OP_READ;
        i_address    = '0;
        i_size_bytes = 4'd1;
        i_write_data = '0;
        i_out_stall  = 1'b0;
        in_fire      = 1'b0;
        out_fire     = 1'b0;
        in_calm      = 1'b0;
        out_calm     = 1'b0;
        gap_left     = 0;
        hold_left    = 0;
        mismatch_count = 0;
        replies_seen   = 0;
        idle_cycles    = 0;
        cur_rom_base   = ROM_BASE_RESET;
        cur_rom_length = '0;
        // Main RAM reads as zero after reset.
        for (k = 0; k < MAIN_RAM_BYTES; k++)
            ram_image[k] = 8'h00;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed beats with the reset window settings: an empty ROM window.
        // Big-endian store through one segment, loads back through the others.
        queue_beat(make_beat(OP_WRITE, 32'h0000_0000, 4'd8, 64'h0102_0304_0506_0708));
        queue_beat(make_beat(OP_READ,  32'h8000_0000, 4'd8, '1));
        queue_beat(make_beat(OP_READ,  32'hC000_0003, 4'd1, '0));
        queue_beat(make_beat(OP_READ,  32'h0000_0006, 4'd2, '0));
        // Last bytes of RAM, then an access running past the end.
        queue_beat(make_beat(OP_WRITE, 32'hC000_FFFC, 4'd4, 64'hFFFF_FFFF_A1B2_C3D4));
        queue_beat(make_beat(OP_READ,  32'h8000_FFF8, 4'd8, '0));
        queue_beat(make_beat(OP_WRITE, 32'h0000_FFFC, 4'd8, '1));
        queue_beat(make_beat(OP_READ,  32'h0000_FFFC, 4'd4, '0));
        // One past the end of RAM in a segment is not RAM.
        queue_beat(make_beat(OP_READ,  32'h8001_0000, 4'd1, '0));
        // Bad sizes for every operation, and the spare operation code.
        queue_beat(make_beat(OP_READ,  32'h0000_0000, 4'd3, '0));
        queue_beat(make_beat(OP_FILL,  32'h0000_0000, 4'd0, '1));
        queue_beat(make_beat(OP_WRITE, 32'h0000_0000, 4'd15, '1));
        queue_beat(make_beat(OP_SPARE, 32'h0000_0000, 4'd4, '1));
        // Fills: in range, at the last ROM byte, past the end, and at an
        // offset whose sum with the size would wrap 32 bits.
        queue_beat(make_beat(OP_FILL,  32'h0000_0000, 4'd8, 64'hDEAD_BEEF_0BAD_F00D));
        queue_beat(make_beat(OP_FILL,  32'h0000_FFFF, 4'd1, 64'h5A));
        queue_beat(make_beat(OP_FILL,  32'h0000_FFFE, 4'd4, '1));
        queue_beat(make_beat(OP_FILL,  32'hFFFF_FFFF, 4'd1, '1));
        // An empty window answers as unmapped.
        queue_beat(make_beat(OP_READ,  ROM_BASE_RESET, 4'd4, '0));
        // The PI, DSP, DI, SI, EXI and audio windows, plus edges around them.
        queue_beat(make_beat(OP_READ,  PI_BASE, 4'd4, '0));
        queue_beat(make_beat(OP_WRITE, MI_BASE - 1, 4'd1, '1));
        queue_beat(make_beat(OP_READ,  DSP_BASE, 4'd2, '0));
        queue_beat(make_beat(OP_WRITE, DI_BASE, 4'd4, '1));
        queue_beat(make_beat(OP_READ,  SI_BASE, 4'd4, '0));
        queue_beat(make_beat(OP_WRITE, AUDIO_ADDR - 1, 4'd8, '1));
        queue_beat(make_beat(OP_WRITE, AUDIO_ADDR, 4'd2, '1));
        queue_beat(make_beat(OP_READ,  AUDIO_ADDR + 1, 4'd2, '0));
        queue_beat(make_beat(OP_READ,  PERIPH_END - 1, 4'd1, '0));
        queue_beat(make_beat(OP_READ,  PI_BASE - 1, 4'd1, '0));

        for (k = 0; k < BEATS_PER_PHASE; k++)
            queue_beat(random_beat());
        drain_block();

        // Each later phase moves the ROM window and runs random beats in it.
        for (phase = 1; phase < PHASES; phase++) begin
            case (phase)
                1: begin
                    // Full window at the reset base.
                    write_register(CFG_ROM_BASE, ROM_BASE_RESET);
                    write_register(CFG_ROM_LENGTH, 32'(ROM_SIZE));
                end
                2: begin
                    // Window straddling the end of the cached RAM segment:
                    // the lower half is shadowed by RAM.
                    write_register(CFG_ROM_BASE, 32'h8000_F000);
                    write_register(CFG_ROM_LENGTH, 32'h0000_2000);
                end
                3: begin
                    // Window laid over the DI and SI windows.
                    write_register(CFG_ROM_BASE, DI_BASE);
                    write_register(CFG_ROM_LENGTH, 32'h0000_0800);
                end
                4: begin
                    // One-byte window at the very top of the address space.
                    write_register(CFG_ROM_BASE, 32'hFFFF_FFFF);
                    write_register(CFG_ROM_LENGTH, 32'd1);
                end
                5: begin
                    write_register(CFG_ROM_BASE, 32'h0FFF_F000);
                    write_register(CFG_ROM_LENGTH, 32'(ROM_SIZE - 1));
                end
                6: begin
                    // Base zero with an empty window.
                    write_register(CFG_ROM_BASE, 32'h0000_0000);
                    write_register(CFG_ROM_LENGTH, 32'h0000_0000);
                end
                default: begin
                    // Random settings; the bits above the length field are
                    // junk and must be ignored.
                    write_register(CFG_ROM_BASE, $urandom);
                    write_register(CFG_ROM_LENGTH,
                                   {15'($urandom), 17'($urandom_range(0, ROM_SIZE))});
                end
            endcase
            for (k = 0; k < BEATS_PER_PHASE; k++)
                queue_beat(random_beat());
            drain_block();
        end

        // Give a stray extra result time to show up before the verdict.
        repeat (8) @(negedge i_clk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/cbd_pkg.sv
sv/cbd_ram.sv
sv/cbd_bank.sv
sv/cbd_decode.sv
sv/console_bus_decode_big_endian_ram_core.sv
tb/sv/tb_console_bus_decode_big_endian_ram_core.sv
